FILE: rtl/fec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the feedback comb echo block.
// No dependencies; imported by every module of the block except fec_ram.
package fec_pkg;

	// Storage and sample format
	localparam int HISTORY_DEPTH = 65536;
	localparam int SAMPLE_BITS   = 16;
	localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);
	localparam int FILL_BITS     = $clog2(HISTORY_DEPTH + 1);

	// Configuration registers
	localparam int LEN_BITS      = 17;
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_FRAC     = 15;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = LEN_BITS;

	localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(4096);
	localparam logic [LEN_BITS-1:0]  LEN_MAX    = LEN_BITS'(HISTORY_DEPTH);
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(16384);
	localparam logic [GAIN_BITS-1:0] GAIN_ONE   = GAIN_BITS'(32768);

	// Datapath widths: Q1.15 sample times Q1.15 unsigned gain, then a sum with headroom
	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int SUM_BITS  = SAMPLE_BITS + 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DELAY_LENGTH = 1'b0,
		CFG_DECAY_GAIN   = 1'b1
	} cfg_idx_t;

	// History read request issued with an accepted transaction
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic                 hit;   // entry has been written since reset
	} rd_req_t;

	// History write-back from the last pipeline stage
	typedef struct packed {
		logic                   valid;
		logic [ADDR_BITS-1:0]   addr;
		logic [SAMPLE_BITS-1:0] data;
	} wr_req_t;

endpackage

FILE: rtl/fec_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fec_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/fec_ptr.sv
`timescale 1ns / 1ps
// Configuration registers, circular position pointer and history fill count.
// Depends on fec_pkg.
module fec_ptr
	import fec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     accept,
	input  wr_req_t                  wr,
	output rd_req_t                  rd,
	output logic [GAIN_BITS-1:0]     gain_eff
);

	logic [LEN_BITS-1:0]  len_q;
	logic [GAIN_BITS-1:0] gain_q;
	logic [ADDR_BITS-1:0] pos_q;
	logic [FILL_BITS-1:0] fill_q;

	logic [LEN_BITS-1:0]  len_eff;
	logic [ADDR_BITS-1:0] pos_cur;
	logic [LEN_BITS-1:0]  pos_inc;
	logic [ADDR_BITS-1:0] pos_nxt;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_RESET;
			gain_q <= GAIN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DELAY_LENGTH: len_q  <= cfg_data;
				CFG_DECAY_GAIN:   gain_q <= cfg_data[GAIN_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// Clamp length to [1, depth] and gain to unity
	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (len_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = len_q;
		end
		gain_eff = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
	end

	// Position wraps early if the length was shortened under it
	always_comb begin
		pos_cur = (LEN_BITS'(pos_q) >= len_eff) ? '0 : pos_q;
		pos_inc = LEN_BITS'(pos_cur) + LEN_BITS'(1);
		pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_nxt;
		end
	end

	// Writes always land at or just past the written prefix, so one count
	// marks which entries hold data; the rest read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr.valid && (FILL_BITS'(wr.addr) == fill_q)) begin
			fill_q <= fill_q + FILL_BITS'(1);
		end
	end

	assign rd.addr = pos_cur;
	assign rd.hit  = FILL_BITS'(pos_cur) < fill_q;

`ifndef SYNTHESIS
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (LEN_BITS'(rd.addr) < len_eff))
		else $error("history read beyond effective delay length");

	a_wr_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> (FILL_BITS'(wr.addr) <= fill_q))
		else $error("history write leaves a hole above the fill count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(HISTORY_DEPTH))
		else $error("fill count exceeds history depth");
`endif

endmodule

FILE: rtl/fec_dp.sv
`timescale 1ns / 1ps
// Echo datapath: forwarding, gain multiply, round/add/saturate, write-back, output register.
// Depends on fec_pkg.
module fec_dp
	import fec_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_in_valid,
	output logic                   sample_in_ready,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  rd_req_t                rd,
	input  logic [SAMPLE_BITS-1:0] ram_rdata,
	input  logic [GAIN_BITS-1:0]   gain_eff,
	output logic                   accept,
	output wr_req_t                wr,
	output logic                   sample_out_valid,
	input  logic                   sample_out_ready,
	output logic [SAMPLE_BITS-1:0] sample_out
);

	localparam logic signed [PROD_BITS-1:0] RND_BIAS = PROD_BITS'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [SUM_BITS-1:0]  SAT_MAX  = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_BITS-1:0]  SAT_MIN  = -SAT_MAX - SUM_BITS'(1);

	// Stage 1: history read in flight
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic [ADDR_BITS-1:0]          addr_s1;
	logic                          hit_s1;
	// Stage 2: product ready
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2;
	logic [ADDR_BITS-1:0]          addr_s2;
	logic signed [PROD_BITS-1:0]   prod_s2;
	// Last write-back, covers a read issued on the edge of that write
	logic                          wb_valid_q;
	logic [ADDR_BITS-1:0]          wb_addr_q;
	logic [SAMPLE_BITS-1:0]        wb_data_q;
	// Output register
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_data_q;

	logic out_free, s2_free, s2_adv, s1_free, s1_adv;
	logic signed [SAMPLE_BITS-1:0] h_s1;
	logic signed [PROD_BITS-1:0]   h_ext, g_ext, prod_nx;
	logic signed [PROD_BITS-1:0]   rnd_full;
	logic signed [SUM_BITS-1:0]    sum_raw;
	logic signed [SAMPLE_BITS-1:0] sum_sat;

	// Flow control: each stage moves when the one ahead is free
	always_comb begin
		out_free        = !out_valid_q || sample_out_ready;
		s2_adv          = valid_s2 && out_free;
		s2_free         = !valid_s2 || out_free;
		s1_adv          = valid_s1 && s2_free;
		s1_free         = !valid_s1 || s2_free;
		sample_in_ready = s1_free;
		accept          = sample_in_valid && s1_free;
	end

	// History value: newest of in-flight result, last write, memory, or zero
	always_comb begin
		priority if (valid_s2 && (addr_s2 == addr_s1)) begin
			h_s1 = sum_sat;
		end else if (wb_valid_q && (wb_addr_q == addr_s1)) begin
			h_s1 = wb_data_q;
		end else if (hit_s1) begin
			h_s1 = ram_rdata;
		end else begin
			h_s1 = '0;
		end
		h_ext   = PROD_BITS'(h_s1);
		g_ext   = PROD_BITS'({1'b0, gain_eff});
		prod_nx = h_ext * g_ext;
	end

	// Round Q2.30 to Q1.15, add input, saturate
	always_comb begin
		rnd_full = (prod_s2 + RND_BIAS) >>> GAIN_FRAC;
		sum_raw  = SUM_BITS'(x_s2) + rnd_full[SUM_BITS-1:0];
		if (sum_raw > SAT_MAX) begin
			sum_sat = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (sum_raw < SAT_MIN) begin
			sum_sat = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sum_sat = sum_raw[SAMPLE_BITS-1:0];
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			wb_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= sample_in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s2_adv) begin
				wb_valid_q <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= sample_in;
			addr_s1 <= rd.addr;
			hit_s1  <= rd.hit;
		end
		if (s1_adv) begin
			x_s2    <= x_s1;
			addr_s2 <= addr_s1;
			prod_s2 <= prod_nx;
		end
		if (s2_adv) begin
			wb_addr_q  <= addr_s2;
			wb_data_q  <= sum_sat;
			out_data_q <= sum_sat;
		end
	end

	assign wr.valid         = s2_adv;
	assign wr.addr          = addr_s2;
	assign wr.data          = sum_sat;
	assign sample_out_valid = out_valid_q;
	assign sample_out       = out_data_q;

`ifndef SYNTHESIS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_valid_q && !sample_out_ready) |-> !sample_in_ready)
		else $error("transaction accepted into a full pipeline");

	a_wb_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv |=> (wb_valid_q && (wb_addr_q == $past(addr_s2)) && (out_data_q == wb_data_q)))
		else $error("write-back register out of step with delivered result");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |=> valid_s2)
		else $error("stage 2 result lost while output stalled");
`endif

endmodule

FILE: rtl/feedback_echo_comb.sv
`timescale 1ns / 1ps
// Top level of the feedback comb echo block.
// Depends on fec_pkg, fec_ptr, fec_dp and fec_ram.

// Each sample transaction returns one echoed sample: input plus the history
// entry at the current position times decay_gain (Q1.15, rounded half up),
// saturated to 16 bits and written back to that entry. The block accepts one
// sample per clock until a stalled output fills it; each result goes through
// history read, multiply and round/add/saturate into the output register, and
// a stalled output only blocks input once all three stages are full. The clock
// is set by the feedback loop: the saturated sum of one sample is forwarded
// straight into the multiplier of the next when both hit the same history
// entry. History lives in a single-port-write, single-port-read 64K x 16
// memory; a fill count makes unwritten entries read as zero, so the block is
// ready immediately after reset with no clearing pass. Configuration writes
// take effect on the next accepted sample and should be made while idle.
module feedback_echo_comb
	import fec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     sample_in_valid,
	output logic                     sample_in_ready,
	input  logic [SAMPLE_BITS-1:0]   sample_in,
	output logic                     sample_out_valid,
	input  logic                     sample_out_ready,
	output logic [SAMPLE_BITS-1:0]   sample_out
);

	rd_req_t                rd;
	wr_req_t                wr;
	logic                   accept;
	logic [GAIN_BITS-1:0]   gain_eff;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	fec_ptr u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.wr        (wr),
		.rd        (rd),
		.gain_eff  (gain_eff)
	);

	fec_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (wr.valid),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (accept),
		.raddr (rd.addr),
		.rdata (ram_rdata)
	);

	fec_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_in_valid  (sample_in_valid),
		.sample_in_ready  (sample_in_ready),
		.sample_in        (sample_in),
		.rd               (rd),
		.ram_rdata        (ram_rdata),
		.gain_eff         (gain_eff),
		.accept           (accept),
		.wr               (wr),
		.sample_out_valid (sample_out_valid),
		.sample_out_ready (sample_out_ready),
		.sample_out       (sample_out)
	);

endmodule

FILE: verif/tb_feedback_echo_comb.sv
`timescale 1ns / 1ps
// Self-checking testbench for feedback_echo_comb: sample transactions with random
// gaps, output stalls and a long hold-off, each echo compared to a local predictor.
// Depends on fec_pkg and the feedback_echo_comb RTL.
module tb_feedback_echo_comb;
	import fec_pkg::*;

	localparam int RESET_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int REPORT_LIMIT   = 10;
	localparam int HOLD_CYCLES    = 120;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [CFG_DATA_BITS-1:0] CFG_ALL_ONES = '1;

	typedef enum int {RX_ALWAYS, RX_CHOPPY, RX_RUNS} rx_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     sample_in_valid;
	logic                     sample_in_ready;
	logic [SAMPLE_BITS-1:0]   sample_in;
	logic                     sample_out_valid;
	logic                     sample_out_ready;
	logic [SAMPLE_BITS-1:0]   sample_out;

	// Predictor copy of the echo state and registers
	logic signed [SAMPLE_BITS-1:0] echo_history [HISTORY_DEPTH];
	int unsigned                   echo_pos;
	logic [LEN_BITS-1:0]           echo_len;
	logic [GAIN_BITS-1:0]          echo_gain;
	logic [SAMPLE_BITS-1:0]        pending_echoes [$];

	int       mismatches = 0;
	int       samples_sent = 0;
	int       echoes_checked = 0;
	int       reg_writes = 0;
	int       idle_cycles = 0;
	int       burst_left = 0;
	int       rx_hold_request = 0;
	rx_mode_t rx_mode = RX_ALWAYS;

	feedback_echo_comb dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sample_in_valid  (sample_in_valid),
		.sample_in_ready  (sample_in_ready),
		.sample_in        (sample_in),
		.sample_out_valid (sample_out_valid),
		.sample_out_ready (sample_out_ready),
		.sample_out       (sample_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Echo of one accepted sample; updates history and position like the block
	function automatic logic [SAMPLE_BITS-1:0] predict_echo(logic [SAMPLE_BITS-1:0] raw);
		int unsigned span;
		int unsigned gain;
		int unsigned slot;
		longint      hi;
		longint      lo;
		longint      scaled;
		longint      total;
		span = (echo_len == '0) ? 1 : ((echo_len > LEN_MAX) ? HISTORY_DEPTH : echo_len);
		gain = (echo_gain > GAIN_ONE) ? GAIN_ONE : echo_gain;
		slot = (echo_pos >= span) ? 0 : echo_pos;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		// Q2.30 product rounded half up to Q1.15
		scaled = (longint'(echo_history[slot]) * longint'(gain) +
			(longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
		total = longint'($signed(raw)) + scaled;
		if (total > hi)
			total = hi;
		else if (total < lo)
			total = lo;
		echo_history[slot] = SAMPLE_BITS'(total);
		echo_pos = (slot + 1 >= span) ? 0 : slot + 1;
		return SAMPLE_BITS'(total);
	endfunction

	function automatic void flag_mismatch(string what, logic [SAMPLE_BITS-1:0] want,
			logic [SAMPLE_BITS-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what,
				$signed(want), $signed(got));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Scoreboard: predict on input transactions, compare on output transactions
	always @(posedge clk) begin : check_echoes
		logic [SAMPLE_BITS-1:0] want;
		if (arst_n) begin
			if (sample_out_valid && sample_out_ready) begin
				if (pending_echoes.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: echo %0d with nothing expected", $realtime,
							$signed(sample_out));
				end else begin
					want = pending_echoes.pop_front();
					if (sample_out !== want)
						flag_mismatch("echo mismatch", want, sample_out);
					echoes_checked++;
				end
			end
			if (sample_in_valid && sample_in_ready)
				pending_echoes.push_back(predict_echo(sample_in));
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (sample_in_valid && sample_in_ready) ||
				(sample_out_valid && sample_out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("feedback_echo_comb verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Output side: stall pattern per mode, plus an on-demand long hold-off
	initial begin : receiver
		int hold_left;
		int run_left;
		hold_left = 0;
		run_left = 0;
		sample_out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				sample_out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: sample_out_ready <= 1'b1;
					RX_CHOPPY: sample_out_ready <= ($urandom_range(0, 3) != 0);
					default: begin
						if (run_left > 0) begin
							run_left--;
							sample_out_ready <= 1'b0;
						end else if ($urandom_range(0, 5) == 0) begin
							run_left = $urandom_range(0, 11);
							sample_out_ready <= 1'b0;
						end else begin
							sample_out_ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(logic [SAMPLE_BITS-1:0] value);
		sample_in_valid <= 1'b1;
		sample_in <= value;
		do
			@(posedge clk);
		while (!sample_in_ready);
		@(negedge clk);
		samples_sent++;
	endtask

	// Random samples in bursts; a zero max_gap keeps valid up throughout
	task automatic send_stream(int count, int max_gap);
		int gap;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(0, max_gap);
				if (gap > 0) begin
					sample_in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			send_sample(random_sample());
		end
	endtask

	// Sender pauses until every expected echo has come back
	task automatic wait_drained();
		sample_in_valid <= 1'b0;
		burst_left = 0;
		while (pending_echoes.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t which, logic [CFG_DATA_BITS-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		case (which)
			CFG_DELAY_LENGTH: echo_len = value[LEN_BITS-1:0];
			CFG_DECAY_GAIN:   echo_gain = value[GAIN_BITS-1:0];
		endcase
		reg_writes++;
	endtask

	task automatic run_phase(logic [CFG_DATA_BITS-1:0] len, logic [CFG_DATA_BITS-1:0] gain,
			int count, int max_gap, rx_mode_t mode);
		wait_drained();
		write_reg(CFG_DELAY_LENGTH, len);
		write_reg(CFG_DECAY_GAIN, gain);
		rx_mode = mode;
		send_stream(count, max_gap);
		wait_drained();
	endtask

	// Reset values of both registers, fresh zero history
	task automatic test_reset_defaults();
		logic [SAMPLE_BITS-1:0] seq [6];
		seq = '{SAMPLE_MAX, SAMPLE_MIN, '0, '1, SAMPLE_BITS'(1), SAMPLE_BITS'(16'h5555)};
		rx_mode = RX_ALWAYS;
		foreach (seq[i])
			send_sample(seq[i]);
		wait_drained();
	endtask

	// Length one feeds each echo straight back: saturation both ways,
	// half-up rounding ties, zero gain
	task automatic test_directed_extremes();
		logic [SAMPLE_BITS-1:0] full_seq [6];
		logic [SAMPLE_BITS-1:0] tie_seq [6];
		full_seq = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, '0};
		tie_seq = '{SAMPLE_BITS'(1), '0, '0, SAMPLE_BITS'(-2), '0, '0};
		write_reg(CFG_DELAY_LENGTH, CFG_DATA_BITS'(1));
		write_reg(CFG_DECAY_GAIN, CFG_DATA_BITS'(GAIN_ONE));
		foreach (full_seq[i])
			send_sample(full_seq[i]);
		wait_drained();
		write_reg(CFG_DECAY_GAIN, CFG_DATA_BITS'(GAIN_RESET));
		foreach (tie_seq[i])
			send_sample(tie_seq[i]);
		wait_drained();
		write_reg(CFG_DECAY_GAIN, '0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		wait_drained();
	endtask

	// Zero length, length past the store, full store, gain above one
	task automatic test_register_limits();
		run_phase('0, CFG_DATA_BITS'(16'hFFFF), 30, 4, RX_CHOPPY);
		run_phase(CFG_ALL_ONES, CFG_ALL_ONES, 30, 0, RX_RUNS);
		run_phase(CFG_DATA_BITS'(LEN_MAX), CFG_DATA_BITS'(GAIN_ONE) + CFG_DATA_BITS'(1),
			30, 6, RX_ALWAYS);
	endtask

	// Position past a shortened length wraps; entries past it keep their contents
	task automatic test_length_shrink();
		run_phase(CFG_DATA_BITS'(200), CFG_DATA_BITS'(24000), 150, 3, RX_RUNS);
		run_phase(CFG_DATA_BITS'(40), CFG_DATA_BITS'(30000), 100, 2, RX_CHOPPY);
		run_phase(CFG_DATA_BITS'(200), CFG_DATA_BITS'(GAIN_ONE), 150, 0, RX_ALWAYS);
	endtask

	task automatic test_random_settings();
		logic [CFG_DATA_BITS-1:0] len;
		logic [CFG_DATA_BITS-1:0] gain;
		int                       pick;
		for (int phase = 0; phase < 10; phase++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				len = CFG_DATA_BITS'($urandom_range(1, 64));
			else if (pick < 9)
				len = CFG_DATA_BITS'($urandom_range(65, 2048));
			else
				len = CFG_DATA_BITS'($urandom);
			pick = $urandom_range(0, 19);
			if (pick < 5)
				gain = CFG_DATA_BITS'(GAIN_ONE);
			else if (pick < 8)
				gain = '0;
			else if (pick < 11)
				gain = CFG_DATA_BITS'($urandom_range(32769, 131071));
			else
				gain = CFG_DATA_BITS'($urandom_range(0, 32768));
			run_phase(len, gain, $urandom_range(80, 140), $urandom_range(0, 8),
				rx_mode_t'($urandom_range(0, 2)));
		end
	endtask

	// Output held off while input keeps coming, so the pipeline fills and stalls
	task automatic test_backpressure();
		wait_drained();
		write_reg(CFG_DELAY_LENGTH, CFG_DATA_BITS'(3));
		write_reg(CFG_DECAY_GAIN, CFG_DATA_BITS'(24576));
		rx_mode = RX_ALWAYS;
		rx_hold_request = HOLD_CYCLES;
		send_stream(60, 0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_DELAY_LENGTH;
		cfg_data = '0;
		sample_in_valid = 1'b0;
		sample_in = '0;
		foreach (echo_history[i])
			echo_history[i] = '0;
		echo_pos = 0;
		echo_len = LEN_RESET;
		echo_gain = GAIN_RESET;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed_extremes();
		test_register_limits();
		test_length_shrink();
		test_random_settings();
		test_backpressure();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_echoes.size() != 0) begin
			mismatches += pending_echoes.size();
			$display("%0d echoes never arrived", pending_echoes.size());
		end
		$display("Ran %0d samples, checked %0d echoes, %0d register writes, %0d mismatches.",
			samples_sent, echoes_checked, reg_writes, mismatches);
		$display("Covered lengths 0 to past the store, gains 0 to above one, gaps and stalls.");
		if (mismatches == 0)
			$display("feedback_echo_comb verification clean");
		else
			$display("feedback_echo_comb verification failed");
		$finish;
	end

endmodule
